// File: rtl/core/tga_rle_pixel_decoder_macros.svh
// assertion helpers for the tga run-length pixel decoder
// both expect clk and rst_n in the scope where they are used
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// consequent checked in the same cycle
`define TRD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trd check failed");

// consequent checked in the next cycle
`define TRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trd check failed");

`endif

// File: rtl/core/trd_pkg.sv
package trd_pkg;

    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam int unsigned RUN_FLAG_BIT = 7;
    localparam logic [2:0] PIXEL_BYTES_THREE = 3'd3;

    typedef enum logic [1:0] {
        CFG_RLE_MODE     = 2'd0,
        CFG_PIXEL_BYTES  = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } cfg_index_t;

    // settings seen by the parser, plus the restart pulse from a register write
    typedef struct packed {
        logic        restart;
        logic        rle_mode;
        logic        three_byte;
        logic [31:0] image_pixels;
    } trd_ctrl_t;

    typedef struct packed {
        logic [31:0] pixel_bgra;
        logic [7:0]  repeat_res;
        logic        last_pixel;
        logic        overrun;
    } trd_result_t;

endpackage

// File: rtl/core/trd_parse.sv
module trd_parse
(
    input  logic                clk,
    input  logic                rst_n,
    input  trd_pkg::trd_ctrl_t  ctrl,
    input  logic                byte_valid,
    input  logic [7:0]          data_byte,
    output logic                res_valid,
    output trd_pkg::trd_result_t res
);

    logic        expect_header_reg, expect_header_next;
    logic        in_run_reg, in_run_next;
    logic [7:0]  pkt_left_reg, pkt_left_next;
    logic [1:0]  byte_pos_reg, byte_pos_next;
    logic [23:0] partial_reg, partial_next;
    logic [31:0] img_left_reg, img_left_next;
    logic        done_reg, done_next;

    logic [1:0]  last_pos;
    logic [7:0]  count;
    logic        over;
    logic [7:0]  pkt_dec;

    assign last_pos = ctrl.three_byte ? 2'd2 : 2'd3;

    always_comb
    begin
        expect_header_next = expect_header_reg;
        in_run_next        = in_run_reg;
        pkt_left_next      = pkt_left_reg;
        byte_pos_next      = byte_pos_reg;
        partial_next       = partial_reg;
        img_left_next      = img_left_reg;
        done_next          = done_reg;
        res_valid          = 1'b0;
        over               = 1'b0;
        count              = 8'd1;
        pkt_dec            = pkt_left_reg;
        res.pixel_bgra     = ctrl.three_byte
                             ? {trd_pkg::ALPHA_OPAQUE, data_byte, partial_reg[15:0]}
                             : {data_byte, partial_reg};
        res.repeat_res     = 8'd1;
        res.last_pixel     = 1'b0;
        res.overrun        = 1'b0;

        if (ctrl.restart)
        begin
            expect_header_next = ctrl.rle_mode;
            in_run_next        = 1'b0;
            pkt_left_next      = 8'd0;
            byte_pos_next      = 2'd0;
            partial_next       = 24'd0;
            img_left_next      = ctrl.image_pixels;
            done_next          = (ctrl.image_pixels == 32'd0);
        end
        else if (byte_valid && !done_reg)
        begin
            if (ctrl.rle_mode && expect_header_reg)
            begin
                in_run_next        = data_byte[trd_pkg::RUN_FLAG_BIT];
                pkt_left_next      = {1'b0, data_byte[6:0]} + 8'd1;
                expect_header_next = 1'b0;
                byte_pos_next      = 2'd0;
                partial_next       = 24'd0;
            end
            else if (byte_pos_reg < last_pos)
            begin
                unique case (byte_pos_reg)
                    2'd0:    partial_next[7:0]   = data_byte;
                    2'd1:    partial_next[15:8]  = data_byte;
                    default: partial_next[23:16] = data_byte;
                endcase
                byte_pos_next = byte_pos_reg + 2'd1;
            end
            else
            begin
                byte_pos_next = 2'd0;
                partial_next  = 24'd0;
                if (ctrl.rle_mode)
                begin
                    over = ({24'd0, pkt_left_reg} > img_left_reg);
                    if (in_run_reg)
                    begin
                        // clipped runs only happen when fewer than 128 pixels remain
                        count   = over ? img_left_reg[7:0] : pkt_left_reg;
                        pkt_dec = 8'd0;
                    end
                    else if (pkt_left_reg != 8'd0)
                    begin
                        pkt_dec = pkt_left_reg - 8'd1;
                    end
                    pkt_left_next = pkt_dec;
                    if (pkt_dec == 8'd0)
                    begin
                        expect_header_next = 1'b1;
                    end
                end
                img_left_next  = img_left_reg - {24'd0, count};
                done_next      = (img_left_next == 32'd0);
                res_valid      = 1'b1;
                res.repeat_res = count;
                res.last_pixel = done_next;
                res.overrun    = over;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b0;
            in_run_reg        <= 1'b0;
            pkt_left_reg      <= 8'd0;
            byte_pos_reg      <= 2'd0;
            partial_reg       <= 24'd0;
            img_left_reg      <= 32'd1;
            done_reg          <= 1'b0;
        end
        else
        begin
            expect_header_reg <= expect_header_next;
            in_run_reg        <= in_run_next;
            pkt_left_reg      <= pkt_left_next;
            byte_pos_reg      <= byte_pos_next;
            partial_reg       <= partial_next;
            img_left_reg      <= img_left_next;
            done_reg          <= done_next;
        end
    end

endmodule

// File: rtl/core/trd_out.sv
module trd_out
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  trd_pkg::trd_result_t res,
    output logic                 space,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,
    output logic                 m_tlast,
    output logic [0:0]           m_tuser
);

    logic                 valid_reg, valid_next;
    trd_pkg::trd_result_t res_reg;

    // new result may land when the register is empty or drains this cycle
    assign space = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.repeat_res, res_reg.pixel_bgra};
    assign m_tlast  = res_reg.last_pixel;
    assign m_tuser  = res_reg.overrun;

endmodule

// File: rtl/core/tga_rle_pixel_decoder.sv
// channel   dir  signals                       contents
// s_axis    in   s_tvalid s_tready s_tdata     data_byte [7:0]
// m_axis    out  m_tvalid m_tready m_tdata     pixel_bgra [31:0], repeat_res [39:32]
//                m_tlast m_tuser               last_pixel; overrun [0]
// cfg       in   cfg_we cfg_index cfg_data     register write, no read-back
//
// one byte per cycle while s_tready is high, result in the output register the cycle after the byte transfer
// header and partial pixel bytes give no result; bytes after the last pixel are dropped
// rst_n clears all state but the output data register asynchronously; any register write restarts decoding
// s_tready drops only while a result is held in the output register and m_tready is low
module tga_rle_pixel_decoder
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // data_byte
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [39:0]                          m_tdata,   // pixel_bgra, repeat_res
    output logic                                 m_tlast,
    output logic [0:0]                           m_tuser,   // overrun
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [trd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic        rle_mode_reg, rle_mode_next;
    logic [2:0]  pixel_bytes_reg, pixel_bytes_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;

    trd_pkg::trd_ctrl_t   ctrl;
    trd_pkg::trd_result_t res;
    logic                 res_valid;
    logic                 space;

    always_comb
    begin
        rle_mode_next    = rle_mode_reg;
        pixel_bytes_next = pixel_bytes_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        if (cfg_we)
        begin
            unique case (trd_pkg::cfg_index_t'(cfg_index))
                trd_pkg::CFG_RLE_MODE:     rle_mode_next    = cfg_data[0];
                trd_pkg::CFG_PIXEL_BYTES:  pixel_bytes_next = cfg_data[2:0];
                trd_pkg::CFG_IMAGE_WIDTH:  width_next       = cfg_data[15:0];
                trd_pkg::CFG_IMAGE_HEIGHT: height_next      = cfg_data[15:0];
                default:                   rle_mode_next    = rle_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_mode_reg    <= 1'b0;
            pixel_bytes_reg <= 3'd4;
            width_reg       <= 16'd1;
            height_reg      <= 16'd1;
        end
        else
        begin
            rle_mode_reg    <= rle_mode_next;
            pixel_bytes_reg <= pixel_bytes_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
        end
    end

    // restart loads the pixel count straight from the new register values
    assign ctrl.restart      = cfg_we;
    assign ctrl.rle_mode     = cfg_we ? rle_mode_next : rle_mode_reg;
    assign ctrl.three_byte   = (pixel_bytes_reg == trd_pkg::PIXEL_BYTES_THREE);
    assign ctrl.image_pixels = {16'd0, width_next} * {16'd0, height_next};

    assign s_tready = space;

    trd_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .byte_valid (s_tvalid && space),
        .data_byte  (s_tdata),
        .res_valid  (res_valid),
        .res        (res)
    );

    trd_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// File: rtl/core/trd_checker.sv
`include "tga_rle_pixel_decoder_macros.svh"

module trd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_we
);

    // a held result keeps its data while stalled
    `TRD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // an empty output register never backpressures the input
    `TRD_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)

    // every result repeats its pixel at least once
    `TRD_ASSERT_NOW(a_repeat_nonzero, m_tvalid, m_tdata[39:32] != 8'd0)

    // nothing follows the last pixel until a register write restarts the image
    `TRD_ASSERT_NEXT(a_quiet_after_last, m_tvalid && m_tready && m_tlast && !cfg_we,
                     !m_tvalid)

endmodule

bind tga_rle_pixel_decoder trd_checker u_trd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we)
);
